// ----- rtl/pwad_pkg.sv -----
`default_nettype none
package pwad_pkg;

    localparam int HISTORY_DEPTH = 9;
    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = 32 + FILL_W;

    localparam int DIV_NW = 49;
    localparam int DIV_DW = 48;
    localparam int DIV_CW = 6;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_HOLD = 2'd1;
    localparam logic [1:0] STATUS_NEG  = 2'd2;

    typedef logic signed [31:0] t_word;
    typedef logic [47:0] t_time;

    typedef struct packed {
        t_word       prop_gain;
        t_word       deriv_gain;
        t_word       integ_gain;
        logic [30:0] integral_limit;
        logic [30:0] output_limit;
    } t_cfg;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
        return r;
    endfunction

    // zero stays zero, anything at or past the limit pins to +/- limit
    function automatic t_word clamp_mag(input logic signed [49:0] v, input logic [30:0] lim);
        logic [49:0] m;
        t_word r;
        m = v[49] ? (50'd0 - $unsigned(v)) : $unsigned(v);
        if (v == 50'sd0) begin
            r = 32'sd0;
        end else if (m >= {19'd0, lim}) begin
            r = v[49] ? $signed(32'd0 - {1'b0, lim}) : $signed({1'b0, lim});
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pwad_in_if.sv -----
`default_nettype none
interface pwad_in_if;
    import pwad_pkg::*;
    logic  valid;
    logic  ready;
    t_word error_value;
    t_time sample_time;
    modport source(output valid, output error_value, output sample_time, input ready);
    modport sink(input valid, input error_value, input sample_time, output ready);
endinterface
`default_nettype wire

// ----- rtl/pwad_out_if.sv -----
`default_nettype none
interface pwad_out_if;
    import pwad_pkg::*;
    logic       valid;
    logic       ready;
    t_word      drive;
    logic [1:0] status;
    modport source(output valid, output drive, output status, input ready);
    modport sink(input valid, input drive, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/pwad_regs.sv -----
`default_nettype none
module pwad_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pwad_pkg::PADDR_W-1:0]  paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pwad_pkg::t_cfg               o_cfg
);
    import pwad_pkg::*;

    t_cfg r_cfg;
    logic [2:0] idx;

    assign idx = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_PROP_GAIN:   r_cfg.prop_gain <= pwdata;
                REG_DERIV_GAIN:  r_cfg.deriv_gain <= pwdata;
                REG_INTEG_GAIN:  r_cfg.integ_gain <= pwdata;
                REG_INTEG_LIMIT: r_cfg.integral_limit <= pwdata[30:0];
                REG_OUT_LIMIT:   r_cfg.output_limit <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PROP_GAIN:   prdata = r_cfg.prop_gain;
            REG_DERIV_GAIN:  prdata = r_cfg.deriv_gain;
            REG_INTEG_GAIN:  prdata = r_cfg.integ_gain;
            REG_INTEG_LIMIT: prdata = {1'b0, r_cfg.integral_limit};
            REG_OUT_LIMIT:   prdata = {1'b0, r_cfg.output_limit};
            default:         prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/pwad_div.sv -----
`default_nettype none
module pwad_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [pwad_pkg::DIV_NW-1:0]  i_num,
    input  wire [pwad_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_done,
    output logic [pwad_pkg::DIV_NW-1:0] o_quo
);
    import pwad_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_r;
    logic [DIV_DW-1:0] r_d;
    logic [DIV_DW:0]   rs;
    logic              fits;

    // restoring, one quotient bit per cycle
    assign rs = {r_r, r_q[DIV_NW-1]};
    assign fits = rs >= {1'b0, r_d};
    assign o_done = r_done;
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (fits) begin
                r_r <= DIV_DW'(rs - {1'b0, r_d});
                r_q <= {r_q[DIV_NW-2:0], 1'b1};
            end else begin
                r_r <= rs[DIV_DW-1:0];
                r_q <= {r_q[DIV_NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pwad_mul.sv -----
`default_nettype none
module pwad_mul (
    input  wire         i_clk,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [63:0] o_prod
);
    import pwad_pkg::*;

    logic [63:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
    end
endmodule
`default_nettype wire

// ----- rtl/pid_with_averaged_derivative.sv -----
`default_nettype none
// PID controller with a moving-average derivative, Q16.16 data and Q32.16 timestamps.
// Each error word gives one result word. A sample whose timestamp equals or precedes
// the previous one returns the held drive with status 1 or 2 by way of S_OUT; the
// first sample goes straight to the multiplier steps; any other sample makes two passes
// through the shared 49-step radix-2 divider (slope, then average), reads back the
// history one entry at a time (S_RD, then S_ACC), and makes seven uses of the
// shared 32x32 multiplier. Input is not ready while a word is in work.
module pid_with_averaged_derivative (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    pwad_in_if.sink                      i_in,
    pwad_out_if.source                   o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pwad_pkg::PADDR_W-1:0]  paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pwad_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SLOPE = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_ACC   = 5'd3;
    localparam logic [4:0] S_AVGS  = 5'd4;
    localparam logic [4:0] S_AVG   = 5'd5;
    localparam logic [4:0] S_MKP   = 5'd6;
    localparam logic [4:0] S_MKD   = 5'd7;
    localparam logic [4:0] S_MKI   = 5'd8;
    localparam logic [4:0] S_MP0   = 5'd9;
    localparam logic [4:0] S_MP1   = 5'd10;
    localparam logic [4:0] S_MP2   = 5'd11;
    localparam logic [4:0] S_MP3   = 5'd12;
    localparam logic [4:0] S_MP4   = 5'd13;
    localparam logic [4:0] S_MP5   = 5'd14;
    localparam logic [4:0] S_INT   = 5'd15;
    localparam logic [4:0] S_DRV   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    t_cfg cfg;

    logic [4:0]              r_state;
    t_word                   r_e;
    t_time                   r_t;
    t_time                   r_dt;
    logic                    r_seen;
    t_word                   r_prev_e;
    t_time                   r_prev_t;
    t_word                   r_iacc;
    t_word                   r_last;
    logic [FILL_W-1:0]       r_fill;
    logic [HIST_AW-1:0]      r_head;
    logic [HIST_AW-1:0]      r_idx;
    logic signed [SUM_W-1:0] r_sum;
    t_word                   r_rdata;
    t_word                   r_avg;
    logic                    r_diffneg;
    logic signed [47:0]      r_pterm;
    logic signed [47:0]      r_dterm;
    logic [61:0]             r_m;
    logic [111:0]            r_acc;
    t_word                   r_res_drive;
    logic [1:0]              r_res_status;
    logic                    r_ovalid;
    t_word                   r_odrive;
    logic [1:0]              r_ostatus;

    t_word                   hist_mem [HISTORY_DEPTH];

    logic                    accept;
    logic                    t_after;
    logic signed [32:0]      diff;
    logic [32:0]             diff_mag;
    logic                    div_start;
    logic [DIV_NW-1:0]       div_num;
    logic [DIV_DW-1:0]       div_den;
    logic                    div_done;
    logic [DIV_NW-1:0]       div_quo;
    t_word                   slope;
    logic [SUM_W-1:0]        sum_mag;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             prod;
    logic signed [47:0]      qterm;
    logic                    ki_pos;
    logic [33:0]             tm;
    logic signed [34:0]      iterm;
    logic signed [49:0]      isum;
    logic signed [49:0]      dsum;
    logic                    out_free;

    pwad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pwad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    pwad_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept = i_in.valid && (r_state == S_IDLE);
    assign t_after = i_in.sample_time > r_prev_t;
    assign diff = {i_in.error_value[31], i_in.error_value} - {r_prev_e[31], r_prev_e};
    assign diff_mag = diff[32] ? (33'd0 - $unsigned(diff)) : $unsigned(diff);
    assign sum_mag = r_sum[SUM_W-1] ? (SUM_W'(0) - $unsigned(r_sum)) : $unsigned(r_sum);
    assign out_free = !r_ovalid || o_out.ready;

    assign o_out.valid = r_ovalid;
    assign o_out.drive = r_odrive;
    assign o_out.status = r_ostatus;

    // slope divide starts on accept, average divide from its own state
    always_comb begin
        div_start = (accept && r_seen && t_after) || (r_state == S_AVGS);
        if (r_state == S_IDLE) begin
            div_num = {diff_mag, 16'd0};
            div_den = i_in.sample_time - r_prev_t;
        end else begin
            div_num = DIV_NW'(sum_mag);
            div_den = DIV_DW'(r_fill);
        end
    end

    always_comb begin
        if (r_diffneg) begin
            slope = (div_quo >= DIV_NW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                          : $signed(32'd0 - div_quo[31:0]);
        end else begin
            slope = (div_quo[DIV_NW-1:31] != '0) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        end
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_state)
            S_MKP: begin
                mul_a = mag32(cfg.prop_gain);
                mul_b = mag32(r_e);
            end
            S_MKD: begin
                mul_a = mag32(cfg.deriv_gain);
                mul_b = mag32(r_avg);
            end
            S_MKI: begin
                mul_a = mag32(cfg.integ_gain);
                mul_b = mag32(r_e);
            end
            S_MP1: begin
                mul_a = r_m[31:0];
                mul_b = r_dt[31:0];
            end
            S_MP2: begin
                mul_a = r_m[31:0];
                mul_b = {16'd0, r_dt[47:32]};
            end
            S_MP3: begin
                mul_a = {2'd0, r_m[61:32]};
                mul_b = r_dt[31:0];
            end
            S_MP4: begin
                mul_a = {2'd0, r_m[61:32]};
                mul_b = {16'd0, r_dt[47:32]};
            end
            default: ;
        endcase
    end

    // product magnitude back to Q16.16, sign applied per state
    always_comb begin
        if (r_state == S_MKD) begin
            qterm = (cfg.prop_gain[31] != r_e[31]) ? $signed(48'd0 - prod[63:16])
                                                    : $signed(prod[63:16]);
        end else begin
            qterm = (cfg.deriv_gain[31] != r_avg[31]) ? $signed(48'd0 - prod[63:16])
                                                       : $signed(prod[63:16]);
        end
    end

    assign ki_pos = !cfg.integ_gain[31] && (cfg.integ_gain != 32'sd0);

    always_comb begin
        if ((r_acc[111:66] != '0) || (r_acc[65] && (r_acc[64:32] != '0))) begin
            tm = 34'h2_0000_0000;
        end else begin
            tm = r_acc[65:32];
        end
        iterm = r_e[31] ? $signed(35'd0 - {1'b0, tm}) : $signed({1'b0, tm});
        isum = 50'(r_iacc) + 50'(iterm);
        dsum = 50'(r_pterm) + 50'(r_dterm) + 50'(r_iacc);
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SLOPE) && div_done) begin
            hist_mem[r_head] <= slope;
        end
        if (r_state == S_RD) begin
            r_rdata <= hist_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen <= 1'b0;
            r_prev_e <= 32'sd0;
            r_prev_t <= '0;
            r_iacc <= 32'sd0;
            r_last <= 32'sd0;
            r_fill <= '0;
            r_head <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_OUT loads the output word itself
            if (r_ovalid && o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_e <= i_in.error_value;
                        r_t <= i_in.sample_time;
                        r_diffneg <= diff[32];
                        r_avg <= 32'sd0;
                        if (!r_seen) begin
                            r_dt <= '0;
                            r_state <= S_MKP;
                        end else if (t_after) begin
                            r_dt <= i_in.sample_time - r_prev_t;
                            r_state <= S_SLOPE;
                        end else begin
                            r_res_drive <= r_last;
                            r_res_status <= (i_in.sample_time == r_prev_t) ? STATUS_HOLD
                                                                           : STATUS_NEG;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SLOPE: begin
                    if (div_done) begin
                        r_head <= (r_head == HIST_AW'(HISTORY_DEPTH - 1)) ? '0
                                                                          : r_head + 1'b1;
                        if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_idx <= '0;
                        r_sum <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= r_sum + SUM_W'(r_rdata);
                    // written entries are always the low fill slots
                    if (FILL_W'(r_idx) == r_fill - 1'b1) begin
                        r_state <= S_AVGS;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_AVGS: begin
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (div_done) begin
                        r_avg <= r_sum[SUM_W-1] ? $signed(32'd0 - div_quo[31:0])
                                                : $signed(div_quo[31:0]);
                        r_state <= S_MKP;
                    end
                end
                S_MKP: begin
                    r_state <= S_MKD;
                end
                S_MKD: begin
                    r_pterm <= qterm;
                    r_state <= S_MKI;
                end
                S_MKI: begin
                    r_dterm <= qterm;
                    r_state <= S_MP0;
                end
                S_MP0: begin
                    r_m <= prod[61:0];
                    r_state <= S_MP1;
                end
                S_MP1: begin
                    r_state <= S_MP2;
                end
                S_MP2: begin
                    r_acc <= {48'd0, prod};
                    r_state <= S_MP3;
                end
                S_MP3: begin
                    r_acc <= r_acc + {16'd0, prod, 32'd0};
                    r_state <= S_MP4;
                end
                S_MP4: begin
                    r_acc <= r_acc + {16'd0, prod, 32'd0};
                    r_state <= S_MP5;
                end
                S_MP5: begin
                    r_acc <= r_acc + {prod[47:0], 64'd0};
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_iacc <= ki_pos ? clamp_mag(isum, cfg.integral_limit) : 32'sd0;
                    r_state <= S_DRV;
                end
                S_DRV: begin
                    r_res_drive <= clamp_mag(dsum, cfg.output_limit);
                    r_last <= clamp_mag(dsum, cfg.output_limit);
                    r_res_status <= STATUS_OK;
                    r_prev_e <= r_e;
                    r_prev_t <= r_t;
                    r_seen <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odrive <= r_res_drive;
                        r_ostatus <= r_res_status;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
